>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define MTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> hw/rtl/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 256;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned DEPTH_USED_W    = 9;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [DEPTH_USED_W-1:0]  depth_used;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

>>> hw/rtl/min_tracking_stack.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload           Handshake
// in_      input      mts_pkg::in_t     in_valid / in_ready
// out_     output     mts_pkg::out_t    out_valid / out_ready
//
// Each result is registered at acceptance, behind any result still stalled.
// The stack and its minimum chain are rows of cells that shift every cell at once.
// A two-entry output queue lets items enter while one result is stalled.
// Reset clears both counts and the output queue; cell contents are left as they are.

module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mts_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mts_pkg::out_t  out_data
);
  import mts_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] value_cnt_r, value_cnt_nxt;
  logic [CNT_W-1:0] min_cnt_r, min_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  out_t             skid_data_r, skid_data_nxt;

  shift_t                   value_shift;
  shift_t                   min_shift;
  logic signed [DATA_W-1:0] value_top;
  logic signed [DATA_W-1:0] value_next;
  logic signed [DATA_W-1:0] min_top;
  logic signed [DATA_W-1:0] min_next;

  logic accept;
  logic out_take;
  logic is_full;
  logic is_empty;
  logic push_ok;
  logic pop_ok;
  out_t result;

  mts_chain #(.DEPTH(STACK_DEPTH)) u_value_chain (
    .clk      (clk),
    .shift    (value_shift),
    .push_val (in_data.push_value),
    .top_val  (value_top),
    .next_val (value_next)
  );

  mts_chain #(.DEPTH(STACK_DEPTH)) u_min_chain (
    .clk      (clk),
    .shift    (min_shift),
    .push_val (in_data.push_value),
    .top_val  (min_top),
    .next_val (min_next)
  );

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  assign is_full  = (value_cnt_r == CNT_W'(STACK_DEPTH));
  assign is_empty = (value_cnt_r == '0);
  assign push_ok  = accept && (in_data.kind == KIND_PUSH) && !is_full;
  assign pop_ok   = accept && (in_data.kind == KIND_POP) && !is_empty;

  always_comb begin
    value_shift.push = push_ok;
    value_shift.pop  = pop_ok;
    min_shift.push   = push_ok && ((min_cnt_r == '0) || (in_data.push_value <= min_top));
    min_shift.pop    = pop_ok && (min_cnt_r != '0) && (value_top == min_top);
  end

  always_comb begin
    value_cnt_nxt = value_cnt_r;
    min_cnt_nxt   = min_cnt_r;
    if (value_shift.push) begin
      value_cnt_nxt = value_cnt_r + CNT_W'(1);
    end else if (value_shift.pop) begin
      value_cnt_nxt = value_cnt_r - CNT_W'(1);
    end
    if (min_shift.push) begin
      min_cnt_nxt = min_cnt_r + CNT_W'(1);
    end else if (min_shift.pop) begin
      min_cnt_nxt = min_cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    result.status = ST_OK;
    if (accept && (in_data.kind == KIND_PUSH) && is_full) begin
      result.status = ST_OVERFLOW;
    end else if (accept && (in_data.kind == KIND_POP) && is_empty) begin
      result.status = ST_UNDERFLOW;
    end

    if (value_cnt_nxt == '0) begin
      result.top_value = '0;
    end else if (value_shift.push) begin
      result.top_value = in_data.push_value;
    end else if (value_shift.pop) begin
      result.top_value = value_next;
    end else begin
      result.top_value = value_top;
    end

    if ((value_cnt_nxt == '0) || (min_cnt_nxt == '0)) begin
      result.min_value = '0;
    end else if (min_shift.push) begin
      result.min_value = in_data.push_value;
    end else if (min_shift.pop) begin
      result.min_value = min_next;
    end else begin
      result.min_value = min_top;
    end

    result.is_empty   = (value_cnt_nxt == '0);
    result.depth_used = DEPTH_USED_W'(value_cnt_nxt);
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = accept;
        skid_data_nxt  = result;
      end else begin
        out_valid_nxt = accept;
        out_data_nxt  = result;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_cnt_r  <= '0;
      min_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      value_cnt_r  <= value_cnt_nxt;
      min_cnt_r    <= min_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/mts_cell.sv
`timescale 1ns / 1ps

module mts_cell (
  input  logic                              clk,
  input  mts_pkg::shift_t                   shift,
  input  logic signed [mts_pkg::DATA_W-1:0] above_val,
  input  logic signed [mts_pkg::DATA_W-1:0] below_val,
  output logic signed [mts_pkg::DATA_W-1:0] val
);
  import mts_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    priority if (shift.push) begin
      val_nxt = above_val;
    end else if (shift.pop) begin
      val_nxt = below_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

>>> hw/rtl/mts_chain.sv
`timescale 1ns / 1ps

module mts_chain #(
  parameter int unsigned DEPTH = mts_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk,
  input  mts_pkg::shift_t                   shift,
  input  logic signed [mts_pkg::DATA_W-1:0] push_val,
  output logic signed [mts_pkg::DATA_W-1:0] top_val,
  output logic signed [mts_pkg::DATA_W-1:0] next_val
);
  import mts_pkg::*;

  logic signed [DATA_W-1:0] cell_val [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] above;
    logic signed [DATA_W-1:0] below;

    if (i == 0) begin : g_head
      assign above = push_val;
    end else begin : g_body
      assign above = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign below = cell_val[i];
    end else begin : g_inner
      assign below = cell_val[i+1];
    end

    mts_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .above_val (above),
      .below_val (below),
      .val       (cell_val[i])
    );
  end

  assign top_val = cell_val[0];

  if (DEPTH > 1) begin : g_next
    assign next_val = cell_val[1];
  end else begin : g_no_next
    assign next_val = '0;
  end

endmodule

>>> hw/rtl/mts_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mts_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input mts_pkg::out_t out_data
);
  import mts_pkg::*;

  // A result held back by the consumer stays put.
  `MTS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // An empty stack reports zero for every value field.
  `MTS_ASSERT(a_empty_zero, clk, rst_n, out_valid && out_data.is_empty |-> out_data.depth_used == '0 && out_data.top_value == '0 && out_data.min_value == '0)

  // The minimum never exceeds the top element.
  `MTS_ASSERT(a_min_le_top, clk, rst_n, out_valid && !out_data.is_empty |-> out_data.min_value <= out_data.top_value)

  // An underflow can only leave the stack empty.
  `MTS_ASSERT(a_underflow_empty, clk, rst_n, out_valid && out_data.status == ST_UNDERFLOW |-> out_data.is_empty)

  // No result is offered straight after reset.
  `MTS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  localparam int unsigned DEPTH = DEF_STACK_DEPTH;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic signed [DATA_W-1:0] val_stack [DEPTH];
  logic signed [DATA_W-1:0] min_chain [DEPTH];
  int unsigned val_count = 0;
  int unsigned min_count = 0;

  out_t pending_results[$];
  int failures = 0;
  int burst_left = 0;
  int hold_cycles = 0;

  rx_mode_t rx_mode = RX_FREE;
  int rx_mode_left = 0;
  int rx_phase = 0;

  min_tracking_stack #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the result of one operation and updates the stack and its chain of minima.
  function automatic out_t stack_step(in_t item);
    logic signed [DATA_W-1:0] v;
    out_t r;
    v = item.push_value;
    r = '0;
    r.status = ST_OK;
    if (item.kind == KIND_PUSH) begin
      if (val_count >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        if (min_count == 0 || v <= min_chain[min_count-1]) begin
          if (min_count < DEPTH) begin
            min_chain[min_count] = v;
            min_count++;
          end
        end
        val_stack[val_count] = v;
        val_count++;
      end
    end else begin
      if (val_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        if (min_count > 0 && val_stack[val_count-1] == min_chain[min_count-1]) begin
          min_count--;
        end
        val_count--;
      end
    end
    if (val_count != 0) begin
      r.top_value = val_stack[val_count-1];
      r.min_value = (min_count != 0) ? min_chain[min_count-1] : '0;
    end
    r.is_empty = (val_count == 0);
    r.depth_used = val_count[DEPTH_USED_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2, 3: v = $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input logic kind, input logic signed [DATA_W-1:0] value);
    in_t item;
    int gap;
    item.kind = kind;
    item.push_value = value;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    pending_results.push_back(stack_step(item));
  endtask

  task automatic push_item(input logic signed [DATA_W-1:0] value);
    send_item(KIND_PUSH, value);
  endtask

  task automatic pop_item();
    send_item(KIND_POP, $urandom);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_pops();
    pop_item();
    pop_item();
    push_item('0);
    pop_item();
    finish_phase();
  endtask

  task automatic test_value_extremes();
    push_item(32'sh7FFFFFFF);
    push_item(32'sh80000000);
    push_item(32'sh80000000);
    push_item(-1);
    push_item('0);
    push_item(32'sh7FFFFFFF);
    repeat (6) pop_item();
    finish_phase();
  endtask

  task automatic test_equal_minima();
    push_item(5);
    push_item(3);
    push_item(3);
    push_item(7);
    push_item(3);
    repeat (5) pop_item();
    finish_phase();
  endtask

  // A non-increasing fill takes the chain of minima to full depth as well.
  task automatic test_fill_and_overflow();
    logic signed [DATA_W-1:0] v;
    v = 32'sh7FFFFFF0;
    while (val_count < DEPTH) begin
      push_item(v);
      v = v - $signed($urandom_range(0, 3));
    end
    push_item(32'sh80000000);
    push_item(32'sh7FFFFFFF);
    push_item(pick_value());
    pop_item();
    push_item(pick_value());
    push_item(32'sh80000000);
    while (val_count != 0) pop_item();
    pop_item();
    finish_phase();
  endtask

  task automatic test_random_walk();
    int push_pct;
    int phase_left;
    push_pct = 50;
    phase_left = 0;
    for (int n = 0; n < 250; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 20;
          1: push_pct = 50;
          2: push_pct = 80;
          default: push_pct = 95;
        endcase
        phase_left = $urandom_range(15, 50);
      end
      phase_left--;
      if ($urandom_range(0, 99) < push_pct) begin
        push_item(pick_value());
      end else begin
        pop_item();
      end
    end
    finish_phase();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 2) != 0) begin
        push_item(pick_value());
      end else begin
        pop_item();
      end
    end
    finish_phase();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(8, 60);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
          RX_FREE: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= (rx_phase % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with none expected");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, out_data.top_value);
          failures++;
        end
        if (out_data.min_value !== want.min_value) begin
          $error("min_value: expected %0d, got %0d", want.min_value, out_data.min_value);
          failures++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
          failures++;
        end
        if (out_data.depth_used !== want.depth_used) begin
          $error("depth_used: expected %0d, got %0d", want.depth_used, out_data.depth_used);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_pops();
    test_value_extremes();
    test_equal_minima();
    test_fill_and_overflow();
    test_random_walk();
    test_backpressure();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("min_tracking_stack verification clean");
    end else begin
      $display("min_tracking_stack verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("min_tracking_stack verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_cell.sv
hw/rtl/mts_chain.sv
hw/rtl/min_tracking_stack.sv
hw/rtl/mts_checker.sv
tb/testbench.sv
